>>> rtl/hfam_pkg.sv
// shared types and constants for the binary16 add/multiply unit
`timescale 1ns / 1ps
`default_nettype none
package hfam_pkg;

	localparam logic [15:0] QNAN = 16'h7E00;
	localparam logic [14:0] INF_MAG = 15'h7C00;
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_MUL = 1'b1;

	// special outcome decided from the operand classes in the first stage
	typedef struct packed {
		logic        special;
		logic [15:0] special_bits;
	} spec_t;

	// unsigned magnitude with its binary scale: value = mag * 2^(scale - 48)
	typedef struct packed {
		logic        neg;
		logic [41:0] mag;
		logic [5:0]  scale;
	} mag_t;

endpackage
`default_nettype wire

>>> rtl/hfam_front.sv
// stage one: special-case detection, operand alignment and product/sum
`timescale 1ns / 1ps
`default_nettype none
module hfam_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                req_type,
	input  wire logic [15:0]         operand_a,
	input  wire logic [15:0]         operand_b,
	output logic                     valid_s1,
	output hfam_pkg::spec_t          spec_s1,
	output hfam_pkg::mag_t           mag_s1
);

	logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [4:0] ea, eb;
	logic [10:0] ma, mb;
	logic [4:0] sa, sb;
	logic [41:0] va, vb, add_mag;
	logic [21:0] prod;
	logic        add_neg;
	hfam_pkg::spec_t spec_d;
	hfam_pkg::mag_t  mag_d;

	// classify and unpack
	always_comb begin
		ea = operand_a[14:10];
		eb = operand_b[14:10];
		a_nan = (ea == 5'h1F) && (operand_a[9:0] != 10'd0);
		b_nan = (eb == 5'h1F) && (operand_b[9:0] != 10'd0);
		a_inf = operand_a[14:0] == hfam_pkg::INF_MAG;
		b_inf = operand_b[14:0] == hfam_pkg::INF_MAG;
		a_zero = operand_a[14:0] == 15'd0;
		b_zero = operand_b[14:0] == 15'd0;
		ma = {(ea != 5'd0), operand_a[9:0]};
		mb = {(eb != 5'd0), operand_b[9:0]};
		sa = (ea == 5'd0) ? 5'd0 : ea - 5'd1;
		sb = (eb == 5'd0) ? 5'd0 : eb - 5'd1;
	end

	// special results
	always_comb begin
		spec_d.special = 1'b1;
		spec_d.special_bits = hfam_pkg::QNAN;
		if (a_nan || b_nan) begin
			spec_d.special_bits = hfam_pkg::QNAN;
		end else if (req_type == hfam_pkg::REQ_ADD) begin
			if (a_inf && b_inf)
				spec_d.special_bits = (operand_a == operand_b) ? operand_a : hfam_pkg::QNAN;
			else if (a_inf)
				spec_d.special_bits = operand_a;
			else if (b_inf)
				spec_d.special_bits = operand_b;
			else
				spec_d.special = 1'b0;
		end else begin
			if (a_inf || b_inf) begin
				if (a_zero || b_zero)
					spec_d.special_bits = hfam_pkg::QNAN;
				else
					spec_d.special_bits = {operand_a[15] ^ operand_b[15], hfam_pkg::INF_MAG};
			end else begin
				spec_d.special = 1'b0;
			end
		end
	end

	// aligned sum in units of 2^-24, raw product scaled by 2^(sa + sb - 48)
	always_comb begin
		va = {31'd0, ma} << sa;
		vb = {31'd0, mb} << sb;
		prod = ma * mb;
		add_neg = 1'b0;
		add_mag = 42'd0;
		if (operand_a[15] == operand_b[15]) begin
			add_mag = va + vb;
			add_neg = operand_a[15];
		end else if (va >= vb) begin
			add_mag = va - vb;
			add_neg = operand_a[15];
		end else begin
			add_mag = vb - va;
			add_neg = operand_b[15];
		end
		if (req_type == hfam_pkg::REQ_MUL) begin
			mag_d.mag = {20'd0, prod};
			mag_d.scale = {1'b0, sa} + {1'b0, sb};
			mag_d.neg = operand_a[15] ^ operand_b[15];
		end else begin
			mag_d.mag = add_mag;
			mag_d.scale = 6'd24;
			mag_d.neg = add_neg;
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		spec_s1 <= spec_d;
		mag_s1 <= mag_d;
	end

endmodule
`default_nettype wire

>>> rtl/hfam_norm.sv
// stages two and three: leading-one search, then truncating pack
`timescale 1ns / 1ps
`default_nettype none
module hfam_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire hfam_pkg::spec_t spec_s1,
	input  wire hfam_pkg::mag_t  mag_s1,
	output logic                 valid_s3,
	output logic [15:0]          bits_s3
);

	logic [5:0]  lead;
	logic        nz;
	logic        valid_s2;
	hfam_pkg::spec_t spec_s2;
	logic        neg_s2, nz_s2;
	logic [5:0]  lead_s2;
	logic [5:0]  scale_s2;
	logic [41:0] mag_s2;
	logic [15:0] bits_d;
	logic [6:0]  pos;
	logic [4:0]  expo;
	logic [41:0] norm_frac;
	logic [41:0] sub_frac;

	// leading one position over the magnitude
	always_comb begin
		lead = 6'd0;
		nz = mag_s1.mag != 42'd0;
		for (int i = 0; i < 42; i++)
			if (mag_s1.mag[i]) lead = 6'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s2 <= spec_s1;
		neg_s2 <= mag_s1.neg;
		nz_s2 <= nz;
		lead_s2 <= lead;
		scale_s2 <= mag_s1.scale;
		mag_s2 <= mag_s1.mag;
	end

	// value = mag * 2^(scale - 48); lead + scale is the exponent plus 48
	// normal when that is 34 or more (2^-14), infinity from 64 (2^16)
	always_comb begin
		pos = {1'b0, lead_s2} + {1'b0, scale_s2};
		expo = 5'(pos - 7'd33);
		norm_frac = (lead_s2 >= 6'd10) ? (mag_s2 >> (lead_s2 - 6'd10))
			: (mag_s2 << (6'd10 - lead_s2));
		sub_frac = (scale_s2 >= 6'd24) ? (mag_s2 << (scale_s2 - 6'd24))
			: (mag_s2 >> (6'd24 - scale_s2));
		bits_d = 16'd0;
		if (spec_s2.special) begin
			bits_d = spec_s2.special_bits;
		end else if (!nz_s2) begin
			bits_d = 16'd0;
		end else if (pos >= 7'd64) begin
			bits_d = {neg_s2, hfam_pkg::INF_MAG};
		end else if (pos >= 7'd34) begin
			bits_d = {neg_s2, expo, norm_frac[9:0]};
		end else begin
			bits_d = {neg_s2, 5'd0, sub_frac[9:0]};
		end
	end

	always_ff @(posedge clk) begin
		bits_s3 <= bits_d;
	end

endmodule
`default_nettype wire

>>> rtl/half_float_add_mul.sv
// top level of the pipelined binary16 adder and multiplier
// start passes through the valid_s1, valid_s2 and valid_s3 registers to done
// throughput: one transaction per cycle, busy is always low
// reset: arst_n clears all stage valid bits asynchronously
// results cannot be stalled; done pulses once per transaction
`timescale 1ns / 1ps
`default_nettype none
module half_float_add_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	output logic             done,
	output logic [15:0]      result_bits
);

	logic            valid_s1;
	hfam_pkg::spec_t spec_s1;
	hfam_pkg::mag_t  mag_s1;

	assign busy = 1'b0;

	// operand front end
	hfam_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
		.valid_s1(valid_s1), .spec_s1(spec_s1), .mag_s1(mag_s1)
	);

	// normalize and pack
	hfam_norm u_norm (
		.clk(clk), .arst_n(arst_n), .valid_s1(valid_s1), .spec_s1(spec_s1),
		.mag_s1(mag_s1), .valid_s3(done), .bits_s3(result_bits)
	);

	// every accepted transaction shows up later as done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("lost transaction");
	// no result without a transaction
	a_noinvent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3)) else $error("spurious result");
	// canonical nan from a nan operand_a
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && operand_a[14:10] == 5'h1F && operand_a[9:0] != 10'd0)
		|-> ##3 (result_bits == hfam_pkg::QNAN)) else $error("nan not canonical");

endmodule
`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for the binary16 add/multiply unit
`timescale 1ns / 1ps
`default_nettype none
module tb;

	typedef struct {
		logic        op;
		logic [15:0] a;
		logic [15:0] b;
		int          gap;
	} hf_req_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic        done;
	logic [15:0] result_bits;

	hf_req_t     pending_q[$];
	logic [15:0] expected_q[$];
	int          error_count;
	int          wait_cnt;
	bit          stim_done;
	bit          drain_req;

	half_float_add_mul dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_bits(result_bits)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// encode (-1)^neg * mag * 2^k as binary16, truncated toward zero
	function automatic logic [15:0] hf_encode(logic neg, logic [63:0] mag, int k);
		int p;
		int e;
		int s;
		logic [63:0] frac;
		if (mag == 0)
			return 16'h0000;
		p = 63;
		while (mag[p] == 1'b0)
			p--;
		e = p + k;
		if (e >= 16)
			return {neg, hfam_pkg::INF_MAG};
		if (e >= -14) begin
			frac = (p >= 10) ? (mag >> (p - 10)) : (mag << (10 - p));
			return {neg, 5'(e + 15), frac[9:0]};
		end
		s = k + 24;
		if (s >= 0)
			frac = mag << s;
		else if (-s >= 64)
			frac = 0;
		else
			frac = mag >> (-s);
		return {neg, 5'd0, frac[9:0]};
	endfunction

	function automatic logic [63:0] hf_mant(logic [15:0] x);
		return (x[14:10] == 0) ? 64'(x[9:0]) : 64'({1'b1, x[9:0]});
	endfunction

	function automatic int hf_shift(logic [15:0] x);
		return (x[14:10] == 0) ? 0 : int'(x[14:10]) - 1;
	endfunction

	// expected sum or product of one transaction
	function automatic logic [15:0] hf_result(logic op, logic [15:0] a, logic [15:0] b);
		logic nan_a;
		logic nan_b;
		logic inf_a;
		logic inf_b;
		longint va;
		longint vb;
		longint sum;
		nan_a = (a[14:10] == 5'h1F) && (a[9:0] != 0);
		nan_b = (b[14:10] == 5'h1F) && (b[9:0] != 0);
		inf_a = (a[14:0] == hfam_pkg::INF_MAG);
		inf_b = (b[14:0] == hfam_pkg::INF_MAG);
		if (nan_a || nan_b)
			return hfam_pkg::QNAN;
		if (op == hfam_pkg::REQ_ADD) begin
			if (inf_a && inf_b)
				return (a == b) ? a : hfam_pkg::QNAN;
			if (inf_a)
				return a;
			if (inf_b)
				return b;
			va = longint'(hf_mant(a) << hf_shift(a));
			vb = longint'(hf_mant(b) << hf_shift(b));
			if (a[15])
				va = -va;
			if (b[15])
				vb = -vb;
			sum = va + vb;
			if (sum < 0)
				return hf_encode(1'b1, 64'(-sum), -24);
			return hf_encode(1'b0, 64'(sum), -24);
		end
		if (inf_a || inf_b) begin
			if (a[14:0] == 0 || b[14:0] == 0)
				return hfam_pkg::QNAN;
			return {a[15] ^ b[15], hfam_pkg::INF_MAG};
		end
		return hf_encode(a[15] ^ b[15], hf_mant(a) * hf_mant(b),
			hf_shift(a) + hf_shift(b) - 48);
	endfunction

	function automatic logic [15:0] rand_operand();
		logic [15:0] x;
		x = 16'($urandom);
		case ($urandom_range(0, 9))
			0: x[14:10] = 5'h1F;
			1: x[14:10] = 5'h00;
			2: x[14:0] = ($urandom_range(0, 1) == 1) ? hfam_pkg::INF_MAG : 15'h0000;
			3: x[14:10] = 5'(13 + $urandom_range(0, 4));
			default: ;
		endcase
		return x;
	endfunction

	task automatic add_req(logic op, logic [15:0] a, logic [15:0] b, int gap);
		hf_req_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.gap = gap;
		pending_q.push_back(r);
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// directed and random stimulus
	initial begin
		logic [15:0] dir_vals[12];
		int          gap;
		dir_vals = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400, 16'h7BFF,
			16'hFBFF, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFC01, 16'h3C00};
		error_count = 0;
		stim_done = 1'b0;
		drain_req = 1'b0;
		for (int i = 0; i < 12; i++)
			add_req(1'(i), dir_vals[i], dir_vals[11 - i], 0);
		add_req(hfam_pkg::REQ_ADD, 16'h7C00, 16'hFC00, 0);
		add_req(hfam_pkg::REQ_ADD, 16'h7C00, 16'h7C00, 1);
		add_req(hfam_pkg::REQ_ADD, 16'h3C00, 16'hBC00, 0);
		add_req(hfam_pkg::REQ_ADD, 16'h8000, 16'h8000, 0);
		add_req(hfam_pkg::REQ_ADD, 16'h7BFF, 16'h7BFF, 2);
		add_req(hfam_pkg::REQ_ADD, 16'h7BFF, 16'h5000, 0);
		add_req(hfam_pkg::REQ_ADD, 16'h7BFF, 16'h4000, 0);
		add_req(hfam_pkg::REQ_MUL, 16'h7C00, 16'h8000, 0);
		add_req(hfam_pkg::REQ_MUL, 16'hFC00, 16'hFC00, 0);
		add_req(hfam_pkg::REQ_MUL, 16'h0001, 16'h8001, 3);
		add_req(hfam_pkg::REQ_MUL, 16'h7BFF, 16'h3C01, 0);
		add_req(hfam_pkg::REQ_MUL, 16'h0400, 16'h3800, 0);
		for (int i = 0; i < 1200; i++) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
			if ((i / 150) % 2 == 1)
				gap = 0;
			add_req(1'($urandom), rand_operand(), rand_operand(), gap);
		end
		wait (pending_q.size() < 600);
		drain_req = 1'b1;
		wait (drain_req == 1'b0);
		wait (pending_q.size() == 0 && start == 1'b0);
		stim_done = 1'b1;
	end

	// driver: one transaction per accepted start
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= 1'b0;
			operand_a <= 16'h0000;
			operand_b <= 16'h0000;
			wait_cnt <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(hf_result(req_type, operand_a, operand_b));
			if (start && busy) begin
				// hold the current transaction
			end else if (drain_req && !start) begin
				if (expected_q.size() == 0 && !done)
					drain_req <= 1'b0;
			end else if (wait_cnt > 0) begin
				start <= 1'b0;
				wait_cnt <= wait_cnt - 1;
			end else if (pending_q.size() > 0 && !(drain_req && start)) begin
				start <= 1'b1;
				req_type <= pending_q[0].op;
				operand_a <= pending_q[0].a;
				operand_b <= pending_q[0].b;
				wait_cnt <= pending_q[0].gap;
				void'(pending_q.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0)
				report_mismatch($sformatf("unexpected result %h", result_bits));
			else begin
				if (result_bits !== expected_q[0])
					report_mismatch($sformatf("result_bits %h, expected %h",
						result_bits, expected_q[0]));
				void'(expected_q.pop_front());
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (expected_q.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
